[design/stg_pkg.sv]
package stg_pkg;

  localparam int unsigned GRID_NODES   = 16;
  localparam int unsigned GHOST_OFFSET = 1;

  localparam logic [1:0] CFG_INV_X = 2'd0;
  localparam logic [1:0] CFG_INV_Y = 2'd1;
  localparam logic [1:0] CFG_INV_Z = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_GATHER = 1'b1;

  localparam logic [23:0] INV_RESET = 24'd65536;

  typedef struct packed {
    logic               operation;
    logic [3:0]         grid_x;
    logic [3:0]         grid_y;
    logic [3:0]         grid_z;
    logic [1:0]         component;
    logic signed [31:0] field_word;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] gathered_x;
    logic signed [31:0] gathered_y;
    logic signed [31:0] gathered_z;
    logic               outside_grid;
  } out_item_t;

  typedef struct packed {
    logic signed [25:0] node;
    logic [16:0]        w0;
    logic [16:0]        w1;
  } env_t;

  function automatic env_t make_env(input logic signed [41:0] cv);
    env_t e;
    e.node = cv[41:16];
    e.w1   = {1'b0, cv[15:0]};
    e.w0   = 17'h10000 - {1'b0, cv[15:0]};
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/stg_ram.sv]
module stg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/stg_mul.sv]
module stg_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[design/staggered_trilinear_field_gather.sv]
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_stall_o  | stg_pkg::in_item_t
// out      | output    | out_valid_o / out_stall_i| stg_pkg::out_item_t
// cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A write item leaves the input unstalled; the next item is accepted on the following edge.
// A gather item first scales the three positions in 4 steps, then runs
// 8 corners times 3 components times 4 steps on the one shared multiplier.
// Each component needs three products (two weight products and the field product).
// Reset clears control and sets the three scale registers to INV_RESET; the field store is undefined until written.
// in_stall_o stays high while a gather runs or waits to load its result behind a stalled earlier output.
module staggered_trilinear_field_gather #(
  parameter int unsigned GridNodes   = stg_pkg::GRID_NODES,
  parameter int unsigned GhostOffset = stg_pkg::GHOST_OFFSET
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stg_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stg_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i
);

  localparam int unsigned IdxW      = $clog2(GridNodes);
  localparam int unsigned AddrW     = 3 * IdxW;
  localparam int unsigned BankDepth = 1 << AddrW;
  localparam logic signed [41:0] GhostC = 42'(GhostOffset) <<< 16;
  localparam logic signed [41:0] HalfC  = 42'sh8000;

  typedef enum logic [1:0] {ST_IDLE, ST_COORD, ST_CORNER, ST_DONE} state_e;

  state_e             state_q, state_d;
  logic [1:0]         step_q, step_d;
  logic [2:0]         corner_q, corner_d;
  logic [1:0]         comp_q, comp_d;
  logic [1:0]         phase_q, phase_d;
  logic [23:0]        inv_q [3];
  logic [31:0]        pos_q [3], pos_d [3];
  logic signed [41:0] coord_q [3], coord_d [3];
  logic signed [51:0] sum_q [3], sum_d [3];
  logic [2:0]         inb_q, inb_d;
  logic               outside_q, outside_d;
  logic               out_valid_q, out_valid_d;
  stg_pkg::out_item_t out_q, out_d;

  logic               in_acc, rd_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  stg_pkg::env_t      env_int [3], env_half [3], e;
  logic [IdxW-1:0]    idx [3][3];
  logic [2:0]         ing [3];
  logic [16:0]        wsel [3][3];
  logic [AddrW-1:0]   raddr [3];
  logic [31:0]        rdata [3];
  logic [2:0]         bank_we;
  logic [AddrW-1:0]   waddr;
  logic [7:0]         gx8, gy8, gz8;
  logic               wr_ok;
  logic               bitv;
  logic [26:0]        nsum;
  logic signed [32:0] fval;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign gx8   = {4'b0, in_item_i.grid_x};
  assign gy8   = {4'b0, in_item_i.grid_y};
  assign gz8   = {4'b0, in_item_i.grid_z};
  assign waddr = {gx8[IdxW-1:0], gy8[IdxW-1:0], gz8[IdxW-1:0]};
  assign wr_ok = in_acc && (in_item_i.operation == stg_pkg::OP_WRITE)
                 && ({5'b0, in_item_i.grid_x} < 9'(GridNodes))
                 && ({5'b0, in_item_i.grid_y} < 9'(GridNodes))
                 && ({5'b0, in_item_i.grid_z} < 9'(GridNodes));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bank_we[c] = wr_ok && (in_item_i.component == 2'(c));
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      env_int[a]  = stg_pkg::make_env(coord_q[a]);
      env_half[a] = stg_pkg::make_env(coord_q[a] - HalfC);
    end
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 3; a++) begin
        e    = (c == a) ? env_int[a] : env_half[a];
        bitv = corner_q[2-a];
        nsum = {e.node[25], e.node} + {26'b0, bitv};
        ing[c][a]  = !nsum[26] && (nsum < 27'(GridNodes));
        idx[c][a]  = nsum[IdxW-1:0];
        wsel[c][a] = bitv ? e.w1 : e.w0;
      end
      raddr[c] = {idx[c][0], idx[c][1], idx[c][2]};
    end
  end

  assign rd_en = (state_q == ST_CORNER) && (comp_q == 2'd0) && (phase_q == 2'd0);

  for (genvar g = 0; g < 3; g++) begin : g_bank
    stg_ram #(
      .Width(32),
      .Depth(BankDepth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .waddr_i(waddr),
      .wdata_i(in_item_i.field_word),
      .re_i   (rd_en),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );
  end

  always_comb begin
    fval  = inb_q[comp_q] ? {rdata[comp_q][31], rdata[comp_q]} : 33'sd0;
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    if (state_q == ST_COORD) begin
      mul_a = {1'b0, pos_q[step_q]};
      mul_b = {9'b0, inv_q[step_q]};
    end else begin
      case (phase_q)
        2'd0: begin
          mul_a = {16'b0, wsel[comp_q][0]};
          mul_b = {16'b0, wsel[comp_q][1]};
        end
        2'd1: begin
          mul_a = {16'b0, prod[32:16]};
          mul_b = {16'b0, wsel[comp_q][2]};
        end
        2'd2: begin
          mul_a = {16'b0, prod[32:16]};
          mul_b = fval;
        end
        default: begin
          mul_a = 33'sd0;
          mul_b = 33'sd0;
        end
      endcase
    end
  end

  stg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    corner_d    = corner_q;
    comp_d      = comp_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    coord_d     = coord_q;
    sum_d       = sum_q;
    inb_d       = inb_q;
    outside_d   = outside_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.operation == stg_pkg::OP_GATHER)) begin
          state_d   = ST_COORD;
          step_d    = 2'd0;
          pos_d[0]  = in_item_i.pos_x;
          pos_d[1]  = in_item_i.pos_y;
          pos_d[2]  = in_item_i.pos_z;
          outside_d = 1'b0;
          for (int c = 0; c < 3; c++) begin
            sum_d[c] = 52'sd0;
          end
        end
      end
      ST_COORD: begin
        if (step_q != 2'd0) begin
          coord_d[step_q - 2'd1] = $signed({2'b00, prod[55:16]}) + GhostC;
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d  = ST_CORNER;
          corner_d = 3'd0;
          comp_d   = 2'd0;
          phase_d  = 2'd0;
        end
      end
      ST_CORNER: begin
        if (rd_en) begin
          for (int c = 0; c < 3; c++) begin
            inb_d[c] = &ing[c];
          end
          outside_d = outside_q || !(&ing[0] && &ing[1] && &ing[2]);
        end
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          sum_d[comp_q] = sum_q[comp_q] + prod[51:0];
          if (comp_q == 2'd2) begin
            comp_d   = 2'd0;
            corner_d = corner_q + 3'd1;
            if (corner_q == 3'd7) begin
              state_d = ST_DONE;
            end
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.gathered_x   = stg_pkg::sat32(sum_q[0][51:16]);
          out_d.gathered_y   = stg_pkg::sat32(sum_q[1][51:16]);
          out_d.gathered_z   = stg_pkg::sat32(sum_q[2][51:16]);
          out_d.outside_grid = outside_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 2'd0;
      corner_q    <= 3'd0;
      comp_q      <= 2'd0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
      outside_q   <= 1'b0;
      inb_q       <= 3'b0;
      inv_q[0]    <= stg_pkg::INV_RESET;
      inv_q[1]    <= stg_pkg::INV_RESET;
      inv_q[2]    <= stg_pkg::INV_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      corner_q    <= corner_d;
      comp_q      <= comp_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      outside_q   <= outside_d;
      inb_q       <= inb_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          stg_pkg::CFG_INV_X: inv_q[0] <= cfg_data_i;
          stg_pkg::CFG_INV_Y: inv_q[1] <= cfg_data_i;
          stg_pkg::CFG_INV_Z: inv_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    coord_q <= coord_d;
    sum_q   <= sum_d;
    out_q   <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> state_q == ST_DONE)
    else $error("pending result overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.operation == stg_pkg::OP_GATHER) |=> state_q == ST_COORD)
    else $error("gather item not started");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COORD && step_q == 2'd3) |=>
      (state_q == ST_CORNER && corner_q == 3'd0 && comp_q == 2'd0 && phase_q == 2'd0))
    else $error("corner sweep did not start at first corner");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORNER && corner_q == 3'd7 && comp_q == 2'd2 && phase_q == 2'd3)
      |=> state_q == ST_DONE)
    else $error("corner sweep did not end");

endmodule

[test/staggered_trilinear_field_gather_tb.sv]
`timescale 1ns / 100ps

module staggered_trilinear_field_gather_tb;

  localparam int NODES = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 120;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  stg_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  stg_pkg::out_item_t out_item_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  staggered_trilinear_field_gather dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  logic signed [31:0] field_mirror [3][NODES][NODES][NODES];
  longint inv_scale [3];
  stg_pkg::out_item_t gathers_due [$];
  int errors;
  int idle_cycles;
  int hold_cycles;
  bit calm;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // filled nodes: the low and high ends of each axis
  function automatic bit node_ok(longint n);
    return (n <= 2) || (n >= NODES - 2);
  endfunction

  function automatic bit pos_ok(longint p, int a);
    longint cc, c, n;
    cc = ((p * inv_scale[a]) >> 16) + (longint'(stg_pkg::GHOST_OFFSET) << 16);
    for (int s = 0; s < 2; s++) begin
      c = (s == 1) ? cc - 32768 : cc;
      n = (c < 0) ? -1 : (c >>> 16);
      if (!node_ok(n) || !node_ok(n + 1)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic stg_pkg::out_item_t gather_field(stg_pkg::in_item_t it);
    stg_pkg::out_item_t r;
    longint node [2][3];
    longint wt [2][3][2];
    longint pos [3];
    longint acc [3];
    longint cc, frac, w, f, nx, ny, nz;
    int ex, ey, ez;
    bit outside;
    pos[0] = longint'(it.pos_x);
    pos[1] = longint'(it.pos_y);
    pos[2] = longint'(it.pos_z);
    outside = 1'b0;
    for (int s = 0; s < 2; s++) begin
      for (int a = 0; a < 3; a++) begin
        cc = ((pos[a] * inv_scale[a]) >> 16) + (longint'(stg_pkg::GHOST_OFFSET) << 16);
        if (s == 1) cc = cc - 32768;
        if (cc < 0) begin
          node[s][a] = -1;
          frac = cc + 65536;
        end else begin
          node[s][a] = cc >>> 16;
          frac = cc & 64'hFFFF;
        end
        wt[s][a][0] = 65536 - frac;
        wt[s][a][1] = frac;
      end
    end
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++)
          for (int c = 0; c < 3; c++) begin
            ex = (c == 0) ? 0 : 1;
            ey = (c == 1) ? 0 : 1;
            ez = (c == 2) ? 0 : 1;
            w = (wt[ex][0][i] * wt[ey][1][j]) >> 16;
            w = (w * wt[ez][2][k]) >> 16;
            nx = node[ex][0] + i;
            ny = node[ey][1] + j;
            nz = node[ez][2] + k;
            if (nx < 0 || ny < 0 || nz < 0 || nx >= NODES || ny >= NODES || nz >= NODES) begin
              outside = 1'b1;
              f = 0;
            end else begin
              f = longint'(field_mirror[c][nx][ny][nz]);
            end
            acc[c] += w * f;
          end
    r.gathered_x = 32'(clamp32(acc[0] >>> 16));
    r.gathered_y = 32'(clamp32(acc[1] >>> 16));
    r.gathered_z = 32'(clamp32(acc[2] >>> 16));
    r.outside_grid = outside;
    return r;
  endfunction

  function automatic void apply_item(stg_pkg::in_item_t it);
    if (it.operation == stg_pkg::OP_WRITE) begin
      if (it.component != 2'd3)
        field_mirror[it.component][it.grid_x][it.grid_y][it.grid_z] = it.field_word;
    end else begin
      gathers_due.push_back(gather_field(it));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(stg_pkg::in_item_t it);
    int gap;
    bit stalled;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    forever begin
      #1;
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
      @(negedge clk_i);
    end
    apply_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (gathers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_scale(logic [1:0] idx, logic [23:0] val);
    bit ready;
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      #1;
      ready = cfg_ready_o;
      @(posedge clk_i);
      if (ready) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    inv_scale[idx] = longint'(val);
  endtask

  function automatic stg_pkg::in_item_t write_item(int x, int y, int z, int c,
                                                   logic [31:0] v);
    stg_pkg::in_item_t it;
    it = '0;
    it.operation = stg_pkg::OP_WRITE;
    it.grid_x = 4'(x);
    it.grid_y = 4'(y);
    it.grid_z = 4'(z);
    it.component = 2'(c);
    it.field_word = v;
    it.pos_x = $urandom();
    it.pos_y = $urandom();
    it.pos_z = $urandom();
    return it;
  endfunction

  function automatic stg_pkg::in_item_t gather_item(logic [31:0] px, logic [31:0] py,
                                                    logic [31:0] pz);
    stg_pkg::in_item_t it;
    it = '0;
    it.operation = stg_pkg::OP_GATHER;
    it.grid_x = 4'($urandom());
    it.grid_y = 4'($urandom());
    it.grid_z = 4'($urandom());
    it.component = 2'($urandom());
    it.field_word = $urandom();
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    return it;
  endfunction

  function automatic logic [31:0] pick_pos(int a);
    longint t, p;
    for (int tries = 0; tries < 32; tries++) begin
      if ($urandom_range(0, 9) == 0) begin
        p = longint'($urandom());
      end else begin
        if ($urandom_range(0, 1) == 0)
          t = longint'($urandom_range(0, 32767));
        else
          t = longint'($urandom_range(13 * 65536 + 32768, 17 * 65536 + 32768));
        p = (t << 16) / inv_scale[a];
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      end
      if (pos_ok(p, a)) return 32'(p);
    end
    return 32'd0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 131072)) - 32'd65536;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom()) >>> 8);
    endcase
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4)
        send_item(write_item($urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom_range(0, 3), pick_word()));
      else
        send_item(gather_item(pick_pos(0), pick_pos(1), pick_pos(2)));
    end
  endtask

  task automatic test_fill_store();
    calm = 1'b1;
    for (int c = 0; c < 3; c++)
      for (int x = 0; x < NODES; x++)
        for (int y = 0; y < NODES; y++)
          for (int z = 0; z < NODES; z++)
            if (node_ok(x) && node_ok(y) && node_ok(z))
              send_item(write_item(x, y, z, c, pick_word()));
    calm = 1'b0;
  endtask

  task automatic test_directed();
    send_item(write_item(15, 15, 15, 0, 32'h7FFF_FFFF));
    send_item(write_item(0, 0, 0, 1, 32'h8000_0000));
    send_item(write_item(3, 4, 5, 3, 32'hDEAD_BEEF));
    send_item(write_item(1, 1, 1, 2, 32'hFFFF_FFFF));
    send_item(gather_item(32'd0, 32'd0, 32'd0));
    send_item(gather_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(gather_item(32'h000E_8000, 32'h000E_8000, 32'h000E_8000));
    send_item(gather_item(32'h000E_FFFF, 32'h0000_8000, 32'h000F_0000));
    send_item(gather_item(32'h0000_7FFF, 32'h000F_0000, 32'h000D_8000));
    send_item(gather_item(32'h0010_0000, 32'h0000_0001, 32'h000E_0000));
    for (int i = 0; i < 8; i++)
      send_item(write_item(14 + i / 4, 14 + (i / 2) % 2, 14 + i % 2, 0, 32'h7FFF_FFFF));
    send_item(gather_item(32'h000E_4000, 32'h000E_4000, 32'h000E_4000));
  endtask

  task automatic test_scale_sweep();
    logic [23:0] sweep [5];
    sweep = '{24'd1, 24'hFF_FFFF, 24'd32768, 24'd131072, 24'd65536};
    foreach (sweep[s]) begin
      set_scale(stg_pkg::CFG_INV_X, sweep[s]);
      set_scale(stg_pkg::CFG_INV_Y, sweep[(s + 1) % 5]);
      set_scale(stg_pkg::CFG_INV_Z, sweep[(s + 2) % 5]);
      run_random(120);
    end
    set_scale(stg_pkg::CFG_INV_X, 24'($urandom_range(1, 24'hFF_FFFF)));
    set_scale(stg_pkg::CFG_INV_Y, 24'($urandom_range(1, 24'hFF_FFFF)));
    set_scale(stg_pkg::CFG_INV_Z, 24'($urandom_range(1, 24'hFF_FFFF)));
    run_random(100);
    set_scale(stg_pkg::CFG_INV_X, stg_pkg::INV_RESET);
    set_scale(stg_pkg::CFG_INV_Y, stg_pkg::INV_RESET);
    set_scale(stg_pkg::CFG_INV_Z, stg_pkg::INV_RESET);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    calm = 1'b1;
    run_random(12);
    calm = 1'b0;
    run_random(100);
  endtask

  task automatic test_drain_pause();
    run_random(50);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (gathers_due.size() != 0) @(posedge clk_i);
    run_random(50);
    calm = 1'b1;
    run_random(200);
    calm = 1'b0;
    run_random(100);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: hold_cycles = $urandom_range(20, 80);
        1, 2, 3, 4: out_stall_i <= 1'b1;
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  initial begin : check_proc
    bit in_acc, out_acc;
    stg_pkg::out_item_t got, want;
    forever begin
      @(negedge clk_i);
      #1;
      in_acc = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      got = out_item_o;
      @(posedge clk_i);
      if (!rst_ni) continue;
      idle_cycles = (in_acc || out_acc) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("staggered_trilinear_field_gather test failed");
        $finish;
      end
      if (out_acc) begin
        if (gathers_due.size() == 0) begin
          $display("%0t: unexpected item %h", $time, got);
          errors++;
        end else begin
          want = gathers_due.pop_front();
          if (got.gathered_x !== want.gathered_x) begin
            $display("%0t: gathered_x expected %h actual %h", $time, want.gathered_x,
                     got.gathered_x);
            errors++;
          end
          if (got.gathered_y !== want.gathered_y) begin
            $display("%0t: gathered_y expected %h actual %h", $time, want.gathered_y,
                     got.gathered_y);
            errors++;
          end
          if (got.gathered_z !== want.gathered_z) begin
            $display("%0t: gathered_z expected %h actual %h", $time, want.gathered_z,
                     got.gathered_z);
            errors++;
          end
          if (got.outside_grid !== want.outside_grid) begin
            $display("%0t: outside_grid expected %b actual %b", $time, want.outside_grid,
                     got.outside_grid);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    calm = 1'b0;
    for (int a = 0; a < 3; a++) inv_scale[a] = longint'(stg_pkg::INV_RESET);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = stg_pkg::CFG_INV_X;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_store();
    test_directed();
    test_scale_sweep();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    if (errors == 0 && gathers_due.size() == 0) begin
      $display("staggered_trilinear_field_gather test passed");
    end else begin
      $display("staggered_trilinear_field_gather test failed");
    end
    $finish;
  end

endmodule
